FILE: design/skt_pkg.sv
// shared types and constants for the sorted key table
// no dependencies; imported by every module of the block
package skt_pkg;

	localparam int KEY_W        = 32;
	localparam int SLOT_W       = 7;
	localparam int OUT_TDATA_W  = 16;
	localparam int DEF_CAPACITY = 64;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_ABSENT = 2'd1,
		STAT_DUP    = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_SRCH,
		S_DONE
	} state_t;

	// broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic cmp_en;
		logic shift_en;
	} cell_ctrl_t;

endpackage

FILE: design/skt_cell.sv
// one slot of the sorted key chain: holds a key, compares it to the request
// and takes its left neighbor's key on an insert; uses skt_pkg
module skt_cell import skt_pkg::*; #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  logic                    clk,
	input  cell_ctrl_t              ctrl,
	input  logic signed [KEY_W-1:0] want,
	input  logic [CNT_W-1:0]        count,
	input  logic signed [KEY_W-1:0] left_key,
	input  logic                    left_lt,
	output logic signed [KEY_W-1:0] key,
	output logic                    lt,
	output logic                    eq
);

	logic signed [KEY_W-1:0] key_q;
	logic                    lt_q;
	logic                    eq_q;
	logic                    valid;

	assign valid = CNT_W'(IDX) < count;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			lt_q <= valid && (key_q < want);
			eq_q <= valid && (key_q == want);
		end
		// cells at and above the insertion slot move up; the boundary cell takes the new key
		if (ctrl.shift_en && !lt_q) begin
			key_q <= left_lt ? want : left_key;
		end
	end

	assign key = key_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

FILE: design/sorted_key_table_search_insert.sv
// Sorted key table with lookup and insert.
// Input channel s_*: s_tuser carries the request kind (lookup or insert),
// s_tdata the signed 32-bit key. Output channel m_*: one result transaction
// per request, m_tdata = found, slot (7 bits), status (2 bits).
// The keys live in a chain of CAPACITY cells. A compare step checks the key in
// every cell at once; a binary search over the registered less-than flags
// then narrows the slot probe by probe until its bounds meet. A final step
// checks for a match, moves the cells at and above the slot up by one place
// on an insert and loads the output register. One request is in flight at a
// time; the next request can be taken the cycle after the result is loaded.
// The output register holds a result while m_tready is low; the next request
// is accepted meanwhile and finishes its search, then waits until the register
// frees. Reset empties the table (the count goes to zero; key storage is not
// cleared) and drops any pending result.
// depends on skt_pkg and skt_cell
module sorted_key_table_search_insert import skt_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [KEY_W-1:0]       s_tdata,   // [31:0] key
	input  logic [0:0]             s_tuser,   // [0] kind
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // [0] found, [7:1] slot, [9:8] status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	state_t state_q, state_d;

	logic                    kind_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        lo_q, hi_q;
	logic                    m_tvalid_q;
	logic                    out_found_q;
	logic [SLOT_W-1:0]       out_slot_q;
	status_t                 out_status_q;

	cell_ctrl_t              ctrl;
	logic signed [KEY_W-1:0] cell_key [CAPACITY];
	logic [CAPACITY-1:0]     lt_vec;
	logic [CAPACITY-1:0]     eq_vec;

	logic             accept;
	logic [CNT_W:0]   mid_sum;
	logic [CNT_W-1:0] mid;
	logic             done_go;
	logic             hit;
	logic             is_full;
	logic             do_ins;
	status_t          status_d;

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			skt_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.want     (key_q),
				.count    (count_q),
				.left_key (key_q),
				.left_lt  (1'b1),
				.key      (cell_key[i]),
				.lt       (lt_vec[i]),
				.eq       (eq_vec[i])
			);
		end else begin : g_rest
			skt_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.want     (key_q),
				.count    (count_q),
				.left_key (cell_key[i-1]),
				.left_lt  (lt_vec[i-1]),
				.key      (cell_key[i]),
				.lt       (lt_vec[i]),
				.eq       (eq_vec[i])
			);
		end
	end

	assign accept   = s_tvalid && s_tready;
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[CNT_W:1];
	assign is_full  = count_q == CNT_W'(CAPACITY);
	// lo can reach CAPACITY, so guard the flag read with the entry count
	assign hit      = (lo_q < count_q) && eq_vec[lo_q[IDX_W-1:0]];
	assign done_go  = (state_q == S_DONE) && (!m_tvalid_q || m_tready);
	assign do_ins   = done_go && (kind_q == KIND_INSERT) && !hit && !is_full;

	always_comb begin
		priority if (kind_q == KIND_LOOKUP) begin
			status_d = hit ? STAT_OK : STAT_ABSENT;
		end else if (hit) begin
			status_d = STAT_DUP;
		end else if (is_full) begin
			status_d = STAT_FULL;
		end else begin
			status_d = STAT_OK;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		ctrl.cmp_en   = 1'b0;
		ctrl.shift_en = do_ins;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				ctrl.cmp_en = 1'b1;
				state_d     = S_SRCH;
			end
			S_SRCH: begin
				if (lo_q >= hi_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (done_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (done_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser[0];
			key_q  <= s_tdata;
			lo_q   <= '0;
			hi_q   <= count_q;
		end else if (state_q == S_SRCH && lo_q < hi_q) begin
			if (lt_vec[mid[IDX_W-1:0]]) begin
				lo_q <= mid + CNT_W'(1);
			end else begin
				hi_q <= mid;
			end
		end
		if (done_go) begin
			out_found_q  <= hit;
			out_slot_q   <= SLOT_W'(lo_q);
			out_status_q <= status_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W - SLOT_W - 3){1'b0}}, out_status_q, out_slot_q, out_found_q};

endmodule

FILE: design/skt_checker.sv
// port-level checks for sorted_key_table_search_insert, attached by bind
// depends on skt_pkg
module skt_checker import skt_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [1:0] status;
	logic       found;

	assign status = m_tdata[SLOT_W+2:SLOT_W+1];
	assign found  = m_tdata[0];

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request at a time: no back-to-back acceptance
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

	a_dup_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == STAT_DUP |-> found)
		else $error("duplicate reported without found");

	a_miss_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status == STAT_ABSENT || status == STAT_FULL) |-> !found)
		else $error("absent or full result marked found");

	// padding bits above status stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:SLOT_W+3] == '0)
		else $error("nonzero padding in result");

endmodule

bind sorted_key_table_search_insert skt_checker u_skt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: bench/tb_sorted_key_table_search_insert.sv
// self-checking bench for sorted_key_table_search_insert: directed and random lookups and inserts
// keeps its own sorted key table to predict each result and compares every output transaction
// depends on skt_pkg and the design sources
module tb_sorted_key_table_search_insert;
	import skt_pkg::*;

	localparam int TABLE_DEPTH = DEF_CAPACITY;
	localparam int RANDOM_ITEMS = 1080;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic                    kind;
		logic signed [KEY_W-1:0] key;
		bit                      drain;  // hold until every result is back
	} request_t;

	typedef struct {
		logic              found;
		logic [SLOT_W-1:0] slot;
		status_t           status;
	} result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [KEY_W-1:0]       s_tdata = '0;
	logic [0:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	request_t pending[$];
	result_t  results_due[$];
	logic signed [KEY_W-1:0] key_pool[$];

	// predictor state
	logic signed [KEY_W-1:0] key_tbl [TABLE_DEPTH];
	int fill = 0;
	int peak_fill = 0;

	int unsigned n_fail = 0;
	int unsigned n_results = 0;
	int unsigned n_by_status [4];
	int unsigned cycles = 0;
	bit req_taken = 1'b0;
	int unsigned idle_left = 0;
	int unsigned tx_calm = 0;
	int unsigned stall_left = 0;
	int unsigned rx_calm = 0;

	sorted_key_table_search_insert #(
		.CAPACITY(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// mostly short gaps, a few long ones, now and then a calm stretch with none
	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(30, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// search the sorted copy; on an insert that misses, add the key when there is room
	function automatic result_t search_insert(input logic kind, input logic signed [KEY_W-1:0] key);
		result_t r;
		int pos;
		logic hit;
		pos = 0;
		while (pos < fill && key_tbl[pos] < key)
			pos++;
		hit = (pos < fill) && (key_tbl[pos] == key);
		r.found = hit;
		r.slot = pos[SLOT_W-1:0];
		if (kind == KIND_LOOKUP) begin
			r.status = hit ? STAT_OK : STAT_ABSENT;
		end else if (hit) begin
			r.status = STAT_DUP;
		end else if (fill >= TABLE_DEPTH) begin
			r.status = STAT_FULL;
		end else begin
			for (int i = fill; i > pos; i--)
				key_tbl[i] = key_tbl[i-1];
			key_tbl[pos] = key;
			fill++;
			if (fill > peak_fill)
				peak_fill = fill;
			r.status = STAT_OK;
		end
		return r;
	endfunction

	function automatic bit in_pool(input logic signed [KEY_W-1:0] key);
		foreach (key_pool[i])
			if (key_pool[i] == key)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic signed [KEY_W-1:0] any_key();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 4))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return 32'sd0;
				3: return -32'sd1;
				default: return 32'sd1;
			endcase
		end
		if (r < 4)
			return $signed($urandom_range(0, 100)) - 32'sd50;
		return $signed($urandom());
	endfunction

	// the largest key is kept out of the table so the top slot shows up as a miss
	function automatic logic signed [KEY_W-1:0] fresh_key();
		logic signed [KEY_W-1:0] k;
		k = any_key();
		while (in_pool(k) || k == KEY_MAX)
			k = $signed($urandom());
		return k;
	endfunction

	function automatic logic signed [KEY_W-1:0] pool_key();
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	task automatic add_req(input logic kind, input logic signed [KEY_W-1:0] key, input bit drain);
		request_t q;
		q.kind = kind;
		q.key = key;
		q.drain = drain;
		pending.push_back(q);
		if (kind == KIND_INSERT && !in_pool(key) && key_pool.size() < TABLE_DEPTH)
			key_pool.push_back(key);
	endtask

	// driver: presents the next pending request once the last one was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_taken) begin
			if (req_taken)
				idle_left = pick_gap(tx_calm);
			if (idle_left > 0) begin
				idle_left--;
				s_tvalid <= 1'b0;
			end else if (pending.size() > 0 && (!pending[0].drain || results_due.size() == 0)) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending[0].key;
				s_tuser <= pending[0].kind;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap(rx_calm);
		end
	end

	// monitor and predictor, both on the rising edge
	always @(posedge clk) begin
		result_t want;
		logic              got_found;
		logic [SLOT_W-1:0] got_slot;
		logic [1:0]        got_status;
		logic [5:0]        got_pad;
		req_taken = 1'b0;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_found = m_tdata[0];
				got_slot = m_tdata[7:1];
				got_status = m_tdata[9:8];
				got_pad = m_tdata[15:10];
				if (results_due.size() == 0) begin
					$error("unexpected result transaction, m_tdata %h", m_tdata);
					n_fail++;
				end else begin
					want = results_due.pop_front();
					n_results++;
					n_by_status[want.status]++;
					if (got_found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, got_found);
						n_fail++;
					end
					if (got_slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, got_slot);
						n_fail++;
					end
					if (got_status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got_status);
						n_fail++;
					end
					if (got_pad !== 6'd0) begin
						$error("pad: expected 0, got %0d", got_pad);
						n_fail++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				req_taken = 1'b1;
				results_due.push_back(search_insert(pending[0].kind, pending[0].key));
				void'(pending.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int unsigned r;
		foreach (n_by_status[i])
			n_by_status[i] = 0;

		// directed: empty table, extremes, hits, misses, duplicates
		add_req(KIND_LOOKUP, 32'sd0, 1'b0);
		add_req(KIND_INSERT, 32'sd0, 1'b0);
		add_req(KIND_INSERT, KEY_MIN, 1'b0);
		add_req(KIND_INSERT, -32'sd1, 1'b0);
		add_req(KIND_INSERT, 32'sd1, 1'b0);
		add_req(KIND_INSERT, 32'sh5555_5555, 1'b0);
		add_req(KIND_INSERT, 32'shAAAA_AAAA, 1'b0);
		add_req(KIND_LOOKUP, KEY_MIN, 1'b0);
		add_req(KIND_LOOKUP, -32'sd1, 1'b0);
		add_req(KIND_LOOKUP, 32'sd1, 1'b0);
		add_req(KIND_LOOKUP, 32'sh5555_5555, 1'b0);
		add_req(KIND_LOOKUP, KEY_MAX, 1'b0);
		add_req(KIND_LOOKUP, 32'sh8000_0001, 1'b0);
		add_req(KIND_LOOKUP, 32'sd2, 1'b0);
		add_req(KIND_INSERT, KEY_MIN, 1'b0);
		add_req(KIND_INSERT, 32'sd0, 1'b0);
		add_req(KIND_INSERT, 32'sh5555_5555, 1'b0);
		add_req(KIND_LOOKUP, 32'sd0, 1'b0);

		// random: grow the table to capacity, then keep hitting the full table
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			bit drain;
			drain = (i == 0) || (i == RANDOM_ITEMS / 2);
			r = $urandom_range(0, 99);
			if (key_pool.size() < TABLE_DEPTH) begin
				if (r < 55)
					add_req(KIND_INSERT, fresh_key(), drain);
				else if (r < 65)
					add_req(KIND_INSERT, pool_key(), drain);
				else if (r < 85)
					add_req(KIND_LOOKUP, pool_key(), drain);
				else
					add_req(KIND_LOOKUP, any_key(), drain);
			end else begin
				if (r < 35)
					add_req(KIND_LOOKUP, pool_key(), drain);
				else if (r < 55)
					add_req(KIND_LOOKUP, any_key(), drain);
				else if (r < 75)
					add_req(KIND_INSERT, pool_key(), drain);
				else
					add_req(KIND_INSERT, any_key(), drain);
			end
		end
		// top slot on a full table
		add_req(KIND_LOOKUP, KEY_MAX, 1'b0);
		add_req(KIND_INSERT, KEY_MAX, 1'b0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("checked %0d results: %0d ok, %0d absent, %0d duplicate, %0d full",
			n_results, n_by_status[STAT_OK], n_by_status[STAT_ABSENT],
			n_by_status[STAT_DUP], n_by_status[STAT_FULL]);
		$display("table grew to %0d of %0d keys, %0d cycles", peak_fill, TABLE_DEPTH, cycles);
		if (n_fail == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: sorted_key_table_search_insert.f
design/skt_pkg.sv
design/skt_cell.sv
design/sorted_key_table_search_insert.sv
design/skt_checker.sv
bench/tb_sorted_key_table_search_insert.sv
